/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while reset is held
`define CHK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// next-cycle implication built on the clocked form
`define CHK_NEXT(label, ante, cons, msg) \
    `CHK_ASSERT(label, (ante) |=> (cons), msg)

`endif

/* rtl/pstb_pkg.sv */
// types, constants and microcode table of the periodic soft timer bank
`default_nettype none

package pstb_pkg;

    localparam int NUM_CHANNELS = 32;
    localparam int PERIOD_WIDTH = 16;
    localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // operation codes
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_WRITE   = 2'd1;
    localparam logic [1:0] OP_SERVICE = 2'd2;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  channel;
        logic [15:0] period;
    } cmd_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic [31:0] fired_now;
        logic [31:0] pending_mask;
    } res_t;

    typedef logic [PERIOD_WIDTH-1:0] per_t;
    typedef logic [CH_W-1:0]         chan_idx_t;

    // control from the sequencer to the channel memories
    typedef struct packed {
        logic      rd_en;
        chan_idx_t rd_addr;
        logic      per_we;
        logic      el_we;
        chan_idx_t wr_addr;
        per_t      per_wdata;
        per_t      el_wdata;
    } mem_ctl_t;

    // sequencer step codes
    typedef logic [2:0] step_t;
    localparam step_t STEP_IDLE       = 3'd0;
    localparam step_t STEP_TICK_START = 3'd1;
    localparam step_t STEP_TICK_LOOP  = 3'd2;
    localparam step_t STEP_WRITE      = 3'd3;
    localparam step_t STEP_EMIT_SVC   = 3'd4;
    localparam step_t STEP_EMIT       = 3'd5;

    // jump conditions
    localparam logic [1:0] JC_NEXT     = 2'd0;
    localparam logic [1:0] JC_DISPATCH = 2'd1;
    localparam logic [1:0] JC_LOOP     = 2'd2;
    localparam logic [1:0] JC_OUT_WAIT = 2'd3;

    // one control word per step
    typedef struct packed {
        logic [1:0] jc;
        step_t      target;
        logic       cnt_clr;
        logic       rd_issue;
        logic       upd;
        logic       wr_chan;
        logic       emit;
        logic       pend_clr;
        logic       tick_inc;
    } uword_t;

    // microcode rom
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = '0;
        unique case (s)
            STEP_IDLE:
            begin
                w.jc     = JC_DISPATCH;
                w.target = STEP_IDLE;
            end
            STEP_TICK_START:
            begin
                w.jc       = JC_NEXT;
                w.target   = STEP_TICK_LOOP;
                w.cnt_clr  = 1'b1;
                w.rd_issue = 1'b1;
                w.tick_inc = 1'b1;
            end
            STEP_TICK_LOOP:
            begin
                w.jc       = JC_LOOP;
                w.target   = STEP_EMIT;
                w.rd_issue = 1'b1;
                w.upd      = 1'b1;
            end
            STEP_WRITE:
            begin
                w.jc      = JC_NEXT;
                w.target  = STEP_EMIT;
                w.wr_chan = 1'b1;
            end
            STEP_EMIT_SVC:
            begin
                w.jc       = JC_OUT_WAIT;
                w.target   = STEP_IDLE;
                w.emit     = 1'b1;
                w.pend_clr = 1'b1;
            end
            STEP_EMIT:
            begin
                w.jc     = JC_OUT_WAIT;
                w.target = STEP_IDLE;
                w.emit   = 1'b1;
            end
            default:
            begin
                w.jc     = JC_NEXT;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

/* rtl/pstb_chan_mem.sv */
// period and elapsed memories of the timer channels, with per-channel valid bits
`default_nettype none

module pstb_chan_mem (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire pstb_pkg::mem_ctl_t ctl,
    output      pstb_pkg::per_t     rd_period,
    output      pstb_pkg::per_t     rd_elapsed
);
    import pstb_pkg::*;

    per_t                    per_mem_reg [NUM_CHANNELS];
    per_t                    el_mem_reg  [NUM_CHANNELS];
    logic [NUM_CHANNELS-1:0] vld_reg;
    per_t                    rd_per_reg;
    per_t                    rd_el_reg;
    logic                    rd_vld_reg;

    // memory writes
    always_ff @(posedge clk)
    begin
        if (ctl.per_we)
        begin
            per_mem_reg[ctl.wr_addr] <= ctl.per_wdata;
        end
        if (ctl.el_we)
        begin
            el_mem_reg[ctl.wr_addr] <= ctl.el_wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_per_reg <= per_mem_reg[ctl.rd_addr];
            rd_el_reg  <= el_mem_reg[ctl.rd_addr];
        end
    end

    // valid bits: a channel becomes valid on its first period write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctl.per_we)
            begin
                vld_reg[ctl.wr_addr] <= 1'b1;
            end
            if (ctl.rd_en)
            begin
                rd_vld_reg <= vld_reg[ctl.rd_addr];
            end
        end
    end

    // an unwritten channel reads as disabled with zero elapsed count
    assign rd_period  = rd_vld_reg ? rd_per_reg : '0;
    assign rd_elapsed = rd_vld_reg ? rd_el_reg  : '0;

endmodule

`default_nettype wire

/* rtl/periodic_soft_timer_bank.sv */
// Periodic soft timer bank: a bank of periodic millisecond timers.
// The cmd channel takes one transaction per operation: a tick advances the
// 32-bit time counter and walks every channel, a write loads one channel's
// period and clears its elapsed count, a service returns the pending mask
// and clears it. Each command gives exactly one transaction on res.
// A tick walks the channel memories one entry per cycle through their
// single read and write port; the sequencer then emits the result. A write
// goes through the write step and then emits; a service or an unused code
// emits straight away.
// cmd_stall is high while a command is being worked on. A result waits in
// the output register while res_stall is high; the sequencer holds at its
// last step until the register is free, so nothing is lost.
// Reset clears the time, the pending bits and every channel (all disabled);
// no clearing pass is needed, and commands are taken right after reset.
`default_nettype none

module periodic_soft_timer_bank (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cmd_valid,
    output      logic           cmd_stall,
    input  wire pstb_pkg::cmd_t cmd,
    output      logic           res_valid,
    input  wire logic           res_stall,
    output      pstb_pkg::res_t res
);
    import pstb_pkg::*;

    localparam chan_idx_t LAST_CH = CH_W'(NUM_CHANNELS - 1);

    step_t     upc_reg, upc_next;
    uword_t    uw;
    cmd_t      item_reg;
    chan_idx_t cnt_reg, cnt_next;
    logic [31:0] tick_reg, tick_next;
    logic [31:0] fired_reg, fired_next;
    logic [31:0] pending_reg, pending_next;
    logic        res_valid_reg, res_valid_next;
    res_t        res_reg;
    mem_ctl_t    mctl;
    per_t        rd_period;
    per_t        rd_elapsed;
    logic        accept;
    logic        last_ch;
    logic        out_busy;
    logic        emit_go;
    logic        fire;
    logic        chan_ok;
    logic [31:0] ch_bit;

    // control word of the current step
    assign uw       = ucode(upc_reg);
    assign accept   = cmd_valid && !cmd_stall;
    assign last_ch  = (cnt_reg == LAST_CH);
    assign out_busy = res_valid_reg && res_stall;
    assign emit_go  = uw.emit && !out_busy;
    assign chan_ok  = int'(item_reg.channel) < NUM_CHANNELS;
    assign ch_bit   = 32'(1) << cnt_reg;

    assign cmd_stall = (upc_reg != STEP_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // step sequencing with conditional jumps
    always_comb
    begin
        upc_next = upc_reg;
        unique case (uw.jc)
            JC_NEXT:
            begin
                upc_next = uw.target;
            end
            JC_DISPATCH:
            begin
                if (accept)
                begin
                    unique case (cmd.op)
                        OP_TICK:    upc_next = STEP_TICK_START;
                        OP_WRITE:   upc_next = STEP_WRITE;
                        OP_SERVICE: upc_next = STEP_EMIT_SVC;
                        default:    upc_next = STEP_EMIT;
                    endcase
                end
            end
            JC_LOOP:
            begin
                if (last_ch)
                begin
                    upc_next = uw.target;
                end
            end
            JC_OUT_WAIT:
            begin
                if (!out_busy)
                begin
                    upc_next = uw.target;
                end
            end
            default:
            begin
                upc_next = STEP_IDLE;
            end
        endcase
    end

    // channel update of the tick walk
    assign fire = (rd_period != '0) && (rd_period <= rd_elapsed);

    // memory control
    always_comb
    begin
        mctl = '0;
        mctl.rd_en = uw.rd_issue;
        if (uw.cnt_clr || last_ch)
        begin
            mctl.rd_addr = '0;
        end
        else
        begin
            mctl.rd_addr = CH_W'(cnt_reg + 1'b1);
        end
        if (uw.wr_chan)
        begin
            mctl.wr_addr   = item_reg.channel[CH_W-1:0];
            mctl.per_we    = chan_ok;
            mctl.el_we     = chan_ok;
            mctl.per_wdata = PERIOD_WIDTH'(item_reg.period);
            mctl.el_wdata  = '0;
        end
        else
        begin
            mctl.wr_addr  = cnt_reg;
            mctl.el_we    = uw.upd && (rd_period != '0);
            mctl.el_wdata = fire ? PERIOD_WIDTH'(1) : PERIOD_WIDTH'(rd_elapsed + 1'b1);
        end
    end

    // datapath registers
    always_comb
    begin
        cnt_next       = cnt_reg;
        tick_next      = tick_reg;
        fired_next     = fired_reg;
        pending_next   = pending_reg;
        res_valid_next = res_valid_reg && res_stall;
        if (accept)
        begin
            fired_next = '0;
        end
        if (uw.cnt_clr)
        begin
            cnt_next = '0;
        end
        else if (uw.upd)
        begin
            cnt_next = CH_W'(cnt_reg + 1'b1);
        end
        if (uw.tick_inc)
        begin
            tick_next = tick_reg + 32'd1;
        end
        if (uw.upd && fire)
        begin
            fired_next   = fired_reg | ch_bit;
            pending_next = pending_reg | ch_bit;
        end
        if (emit_go)
        begin
            res_valid_next = 1'b1;
            if (uw.pend_clr)
            begin
                pending_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= STEP_IDLE;
            cnt_reg       <= '0;
            tick_reg      <= '0;
            fired_reg     <= '0;
            pending_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            cnt_reg       <= cnt_next;
            tick_reg      <= tick_next;
            fired_reg     <= fired_next;
            pending_reg   <= pending_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= cmd;
        end
        if (emit_go)
        begin
            res_reg.time_ms      <= tick_reg;
            res_reg.fired_now    <= fired_reg;
            res_reg.pending_mask <= pending_reg;
        end
    end

    pstb_chan_mem u_chan_mem (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mctl),
        .rd_period  (rd_period),
        .rd_elapsed (rd_elapsed)
    );

endmodule

`default_nettype wire

/* rtl/pstb_checker.sv */
// port-level checker of the periodic soft timer bank and its bind
`default_nettype none

`include "assert_macros.svh"

module pstb_checker (
    input wire logic           clk,
    input wire logic           rst_n,
    input wire logic           cmd_valid,
    input wire logic           cmd_stall,
    input wire pstb_pkg::cmd_t cmd,
    input wire logic           res_valid,
    input wire logic           res_stall,
    input wire pstb_pkg::res_t res
);
    import pstb_pkg::*;

    // a stalled result stays offered
    `CHK_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while stalled")

    // a stalled result does not change
    `CHK_NEXT(a_res_stable, res_valid && res_stall, $stable(res), "stalled result changed")

    // a channel only reports firing once its pending bit is set
    `CHK_ASSERT(a_fired_pending, res_valid |-> ((res.fired_now & ~res.pending_mask) == '0), "fired bit without pending bit")

    // a tick keeps the block busy while it walks the channels
    `CHK_ASSERT(a_tick_busy, cmd_valid && !cmd_stall && cmd.op == OP_TICK |-> ##2 cmd_stall, "tick finished too early")

endmodule

bind periodic_soft_timer_bank pstb_checker u_pstb_checker (.*);

`default_nettype wire

/* tb/periodic_soft_timer_bank_tb.sv */
// self-checking testbench of the periodic soft timer bank
`timescale 1ns / 100ps

module periodic_soft_timer_bank_tb;
    import pstb_pkg::*;

    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 450;
    localparam int QUIET_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = NUM_CHANNELS + 8;

    // timer bank predictor and queue of awaited results
    class timer_bank_model;
        per_t        period_tab [NUM_CHANNELS];
        per_t        elapsed_tab [NUM_CHANNELS];
        logic [31:0] pending;
        logic [31:0] now_ms;
        res_t        awaited [$];
        int          errors;
        int          n_tick;
        int          n_write;
        int          n_service;
        int          n_unused;
        int          n_fire;

        function new();
            foreach (period_tab[k])
            begin
                period_tab[k]  = '0;
                elapsed_tab[k] = '0;
            end
            pending   = '0;
            now_ms    = '0;
            errors    = 0;
            n_tick    = 0;
            n_write   = 0;
            n_service = 0;
            n_unused  = 0;
            n_fire    = 0;
        endfunction

        // work out the result of an accepted command transaction
        function void note_command(cmd_t c);
            res_t        r;
            logic [31:0] fired;
            fired = '0;
            case (c.op)
                OP_TICK:
                begin
                    n_tick++;
                    now_ms = now_ms + 32'd1;
                    for (int k = 0; k < NUM_CHANNELS; k++)
                    begin
                        if (period_tab[k] != '0)
                        begin
                            if (period_tab[k] <= elapsed_tab[k])
                            begin
                                elapsed_tab[k] = per_t'(1);
                                fired[k]       = 1'b1;
                            end
                            else
                                elapsed_tab[k] = elapsed_tab[k] + per_t'(1);
                        end
                    end
                    pending        = pending | fired;
                    r.pending_mask = pending;
                    n_fire += $countones(fired);
                end
                OP_WRITE:
                begin
                    n_write++;
                    if (int'(c.channel) < NUM_CHANNELS)
                    begin
                        period_tab[c.channel]  = per_t'(c.period);
                        elapsed_tab[c.channel] = '0;
                    end
                    r.pending_mask = pending;
                end
                OP_SERVICE:
                begin
                    n_service++;
                    r.pending_mask = pending;
                    pending        = '0;
                end
                default:
                begin
                    n_unused++;
                    r.pending_mask = pending;
                end
            endcase
            r.time_ms   = now_ms;
            r.fired_now = fired;
            awaited.push_back(r);
        endfunction

        // compare a result transaction with the oldest awaited one
        function void check_result(res_t got);
            res_t want;
            if (awaited.size() == 0)
            begin
                $error("result with nothing awaited: time_ms %0d", got.time_ms);
                errors++;
                return;
            end
            want = awaited.pop_front();
            if (got.time_ms !== want.time_ms)
            begin
                $error("time_ms: expected %0d, actual %0d", want.time_ms, got.time_ms);
                errors++;
            end
            if (got.fired_now !== want.fired_now)
            begin
                $error("fired_now: expected %h, actual %h", want.fired_now, got.fired_now);
                errors++;
            end
            if (got.pending_mask !== want.pending_mask)
            begin
                $error("pending_mask: expected %h, actual %h",
                       want.pending_mask, got.pending_mask);
                errors++;
            end
        endfunction
    endclass

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd       = '0;
    logic res_valid;
    logic res_stall = 1'b0;
    res_t res;

    int              send_idle_pct = 0;
    int              stall_pct     = 0;
    int              quiet_cycles  = 0;
    timer_bank_model bank;

    periodic_soft_timer_bank i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    // clock
    initial
    begin
        forever #4 clk = ~clk;
    end

    // random receiver stall
    always @(posedge clk)
    begin
        res_stall <= (stall_pct > 0) && ($urandom_range(99) < stall_pct);
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
            bank.check_result(res);
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    function automatic cmd_t make_cmd(logic [1:0] op, logic [4:0] ch, logic [15:0] per);
        cmd_t c;
        c.op      = op;
        c.channel = ch;
        c.period  = per;
        return c;
    endfunction

    // mostly ticks, with writes of short periods so that channels fire often
    function automatic cmd_t random_command();
        cmd_t c;
        int   pick;
        int   span;
        c    = cmd_t'($urandom);
        pick = $urandom_range(99);
        if (pick < 55)
            c.op = OP_TICK;
        else if (pick < 80)
        begin
            c.op = OP_WRITE;
            span = $urandom_range(99);
            if (span < 70)
                c.period = 16'($urandom_range(1, 12));
            else if (span < 80)
                c.period = '0;
            else if (span < 90)
                c.period = 16'($urandom_range(13, 200));
            else
                c.period = 16'($urandom);
        end
        else if (pick < 95)
            c.op = OP_SERVICE;
        else
            c.op = OP_UNUSED;
        return c;
    endfunction

    // drive one command transaction, with random idle cycles ahead of it
    task automatic send_command(input cmd_t c);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            cmd_valid <= 1'b0;
            @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd       <= c;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        bank.note_command(c);
    endtask

    // hold the sender off until every awaited result has come back
    task automatic wait_all_results();
        cmd_valid <= 1'b0;
        while (bank.awaited.size() != 0)
            @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        bank = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, unused code, period extremes, firing and clearing
        send_command(make_cmd(OP_SERVICE, 5'd0, 16'h0000));
        send_command(make_cmd(OP_TICK, 5'd0, 16'h0000));
        send_command(make_cmd(OP_UNUSED, 5'd31, 16'hffff));
        send_command(make_cmd(OP_WRITE, 5'd0, 16'h0001));
        send_command(make_cmd(OP_WRITE, 5'd31, 16'h0002));
        send_command(make_cmd(OP_WRITE, 5'd17, 16'hffff));
        send_command(make_cmd(OP_WRITE, 5'd10, 16'h0003));
        send_command(make_cmd(OP_WRITE, 5'd21, 16'h5555));
        repeat (6) send_command(make_cmd(OP_TICK, 5'd31, 16'hffff));
        send_command(make_cmd(OP_SERVICE, 5'd31, 16'hffff));
        send_command(make_cmd(OP_SERVICE, 5'd0, 16'h0000));
        send_command(make_cmd(OP_WRITE, 5'd0, 16'h0000));
        send_command(make_cmd(OP_WRITE, 5'd31, 16'h0001));
        send_command(make_cmd(OP_TICK, 5'd0, 16'h0000));
        send_command(make_cmd(OP_TICK, 5'd0, 16'h0000));
        send_command(make_cmd(OP_UNUSED, 5'd0, 16'h0000));
        send_command(make_cmd(OP_WRITE, 5'd10, 16'haaaa));
        send_command(make_cmd(OP_TICK, 5'd15, 16'h8000));
        send_command(make_cmd(OP_SERVICE, 5'd16, 16'h7fff));
        wait_all_results();

        // random phases: free flow, idle sender, stalling receiver, both
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1:
                begin
                    send_idle_pct = 76;
                    stall_pct     = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct     = 76;
                end
                default:
                begin
                    send_idle_pct = 35;
                    stall_pct     = 35;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                send_command(random_command());
                if ($urandom_range(99) == 0)
                    wait_all_results();
            end
            wait_all_results();
        end

        // let the block settle, then report
        stall_pct = 0;
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("run covered %0d ticks, %0d period writes, %0d services, %0d unused codes",
                 bank.n_tick, bank.n_write, bank.n_service, bank.n_unused);
        $display("%0d channel firings predicted, time reached %0d ms",
                 bank.n_fire, bank.now_ms);
        if (bank.errors == 0 && bank.awaited.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/pstb_pkg.sv
rtl/pstb_chan_mem.sv
rtl/periodic_soft_timer_bank.sv
rtl/pstb_checker.sv
tb/periodic_soft_timer_bank_tb.sv
